/* src/aih_pkg.sv */
// ----------------------------------------------------------------------------
// Anagram-invariant hash package
// Shared constants, payload structs and control structs for the sort chain
// and the hash accumulator.
// ----------------------------------------------------------------------------
package aih_pkg;

  // Room in the sort chain, in characters.
  localparam int MAX_LEN = 32;
  // Width of the character counter: it must hold MAX_LEN itself.
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam int CHAR_W = 8;
  localparam int HASH_W = 32;
  localparam int LEN_W  = 6;

  localparam logic [HASH_W-1:0] HASH_SEED  = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  typedef struct packed {
    logic signed [CHAR_W-1:0] char_code;
    logic                     last_char;
  } in_word_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic [LEN_W-1:0]  word_length;
    logic              overflow;
  } out_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [CHAR_W-1:0] char_code;
  } cell_ctrl_t;

  // Command to the hash accumulator.
  typedef struct packed {
    logic                     init;
    logic                     step;
    logic signed [CHAR_W-1:0] char_code;
  } hash_ctrl_t;

endpackage

/* src/aih_cell.sv */
// ----------------------------------------------------------------------------
// Sort chain cell
// Holds one character. On insert it keeps its value, takes its left
// neighbour's value or takes the new character; on shift it takes its right
// neighbour's value so the chain drains towards cell zero.
// ----------------------------------------------------------------------------
module aih_cell
  import aih_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     occupied,
  input  logic                     tail,
  input  logic                     prev_gt,
  input  logic signed [CHAR_W-1:0] prev_val,
  input  logic signed [CHAR_W-1:0] next_val,
  output logic                     gt,
  output logic signed [CHAR_W-1:0] val
);

  // Stored characters greater than the new one move one place right, so
  // equal characters stay ahead of the newcomer.
  assign gt = occupied && (val > ctrl.char_code);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (gt) begin
        val <= prev_gt ? prev_val : ctrl.char_code;
      end else if (tail) begin
        // The tail takes the largest stored character when the chain moves
        // right, and the new character only when nothing is greater.
        val <= prev_gt ? prev_val : ctrl.char_code;
      end
    end else if (ctrl.shift) begin
      val <= next_val;
    end
  end

endmodule

/* src/aih_hash.sv */
// ----------------------------------------------------------------------------
// Hash accumulator
// Runs the hash recurrence h = h * 33 + c with c sign-extended, one
// character per cycle, wrapping at 32 bits.
// ----------------------------------------------------------------------------
module aih_hash
  import aih_pkg::*;
(
  input  logic              clk,
  input  hash_ctrl_t        ctrl,
  output logic [HASH_W-1:0] hash
);

  logic [HASH_W-1:0] char_ext;

  assign char_ext = {{(HASH_W-CHAR_W){ctrl.char_code[CHAR_W-1]}}, ctrl.char_code};

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      hash <= HASH_SEED;
    end else if (ctrl.step) begin
      hash <= (hash << HASH_SHIFT) + hash + char_ext;
    end
  end

endmodule

/* src/anagram_invariant_hash.sv */
// ----------------------------------------------------------------------------
// Anagram-invariant hash, top level
// Sorts the characters of a word in a chain of cells and hashes the sorted
// word, so that every anagram of a word gives the same hash.
// ----------------------------------------------------------------------------
// Words that are not the last of a string only enter the chain. After the last
// word of a string, the stored characters are walked out of the chain into the
// hash accumulator, and the result is registered once the output register is
// free. No new word is taken until the walk of the chain has finished and the
// result has been registered.
// Reset (rst, synchronous) empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module anagram_invariant_hash
  import aih_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_HASH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  char_count;
  logic              overflow_seen;
  logic [CNT_W-1:0]  len_hold;
  logic              ovf_hold;

  logic              in_fire;
  logic              char_nonzero;
  logic              store_full;
  logic              do_insert;
  logic              walk_done;
  logic              load_result;
  logic [CNT_W-1:0]  count_after;

  cell_ctrl_t        cell_ctrl;
  hash_ctrl_t        hash_ctrl;
  logic [HASH_W-1:0] hash;

  logic signed [CHAR_W-1:0] cell_val [MAX_LEN];
  logic                     cell_gt  [MAX_LEN];

  // Words are taken only while no walk is under way; a zero character is never
  // stored and does not end the string, and a character that finds the chain
  // full is dropped and marks the string as overflowed.
  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign char_nonzero = (in_data.char_code != '0);
  assign store_full   = (char_count == CNT_W'(MAX_LEN));
  assign do_insert    = in_fire && char_nonzero && !store_full;
  assign count_after  = do_insert ? char_count + CNT_W'(1) : char_count;

  // The walk drains the chain towards cell zero, one character per cycle,
  // counting the stored characters down to zero. The result waits in the hash
  // accumulator until the output register is free.
  assign walk_done   = (state == S_HASH) && (char_count == '0);
  assign load_result = walk_done && (!out_valid || out_ready);

  always_comb begin
    cell_ctrl.insert    = do_insert;
    cell_ctrl.shift     = (state == S_HASH) && (char_count != '0);
    cell_ctrl.char_code = in_data.char_code;

    hash_ctrl.init      = in_fire && in_data.last_char;
    hash_ctrl.step      = cell_ctrl.shift;
    hash_ctrl.char_code = cell_val[0];
  end

  // The chain of cells. Each cell is occupied while its index is below the
  // character count; the first free cell is the tail where a new largest
  // character lands.
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic                     occupied;
    logic                     tail;
    logic                     prev_gt;
    logic signed [CHAR_W-1:0] prev_val;
    logic signed [CHAR_W-1:0] next_val;

    assign occupied = (CNT_W'(i) < char_count);
    assign tail     = (CNT_W'(i) == char_count);

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_inner
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_body
      assign next_val = cell_val[i+1];
    end

    aih_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .occupied (occupied),
      .tail     (tail),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .next_val (next_val),
      .gt       (cell_gt[i]),
      .val      (cell_val[i])
    );
  end

  aih_hash u_hash (
    .clk  (clk),
    .ctrl (hash_ctrl),
    .hash (hash)
  );

  // Control: state, character count, overflow flag and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      char_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            char_count <= count_after;
            if (in_data.last_char) begin
              // The counter now paces the walk, so the length and the
              // overflow flag of the word are held aside.
              len_hold      <= count_after;
              ovf_hold      <= overflow_seen || (char_nonzero && store_full);
              overflow_seen <= 1'b0;
              state         <= S_HASH;
            end else if (char_nonzero && store_full) begin
              overflow_seen <= 1'b1;
            end
          end
        end
        S_HASH: begin
          if (char_count != '0) begin
            char_count <= char_count - CNT_W'(1);
          end else if (load_result) begin
            out_data.hash_value  <= hash;
            out_data.word_length <= LEN_W'(len_hold);
            out_data.overflow    <= ovf_hold;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The character count never exceeds the room in the chain.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_W'(MAX_LEN))
    else $error("character count beyond chain length");

  // The walk counts down by exactly one each cycle while characters remain.
  a_walk_step : assert property (@(posedge clk) disable iff (rst)
    (state == S_HASH) && (char_count != '0) |=>
      (char_count == $past(char_count) - CNT_W'(1)))
    else $error("walk counter did not step down");

  // The last word of a string always starts a walk.
  a_last_walks : assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.last_char |=> (state == S_HASH))
    else $error("last word did not start the hash walk");

  // A result is loaded only once the chain has been fully drained.
  a_load_drained : assert property (@(posedge clk) disable iff (rst)
    load_result |-> (char_count == '0) && (state == S_HASH))
    else $error("result loaded before the walk finished");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the anagram-invariant hash
// Drives strings of signed characters, one word per handshake, into the block.
// A behavioural sort-and-hash model runs alongside and predicts every result.
// Each result the block returns is checked field by field against the oldest
// prediction. The run starts with a short table of directed words and strings
// that fill or overflow the store, then moves on to random strings in phases
// of sender and receiver idling, ending with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import aih_pkg::*;

  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int PHASE_ITEMS     = 240;
  localparam int NUM_PHASES      = 5;

  // One row of the directed table. Where typed is set, res is the result that
  // the row's string must give, written out by hand.
  typedef struct packed {
    in_word_t  stim;
    logic      typed;
    out_word_t res;
  } dir_row_t;

  // Side information that follows each word from the driver to the monitor.
  typedef struct packed {
    logic      typed;
    out_word_t res;
  } char_tag_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Empty string: a lone zero character that ends it.
    '{'{8'sd0, 1'b1}, 1'b1, '{32'd5381, 6'd0, 1'b0}},
    // Single characters at the two extremes of the signed range.
    '{'{8'sd127, 1'b1}, 1'b1, '{32'd177700, 6'd1, 1'b0}},
    '{'{8'sh80, 1'b1}, 1'b1, '{32'd177445, 6'd1, 1'b0}},
    // Equal characters, with a zero in the middle that must not be stored.
    '{'{8'sd3, 1'b0}, 1'b0, '0},
    '{'{-8'sd1, 1'b0}, 1'b0, '0},
    '{'{8'sd0, 1'b0}, 1'b0, '0},
    '{'{8'sd3, 1'b0}, 1'b0, '0},
    '{'{-8'sd1, 1'b1}, 1'b0, '0},
    // Arrival in descending order, so every insert goes to the front.
    '{'{8'sd100, 1'b0}, 1'b0, '0},
    '{'{8'sd50, 1'b0}, 1'b0, '0},
    '{'{-8'sd50, 1'b0}, 1'b0, '0},
    '{'{-8'sd100, 1'b1}, 1'b0, '0},
    // Arrival in ascending order, extremes at both ends.
    '{'{8'sh80, 1'b0}, 1'b0, '0},
    '{'{-8'sd1, 1'b0}, 1'b0, '0},
    '{'{8'sd1, 1'b0}, 1'b0, '0},
    '{'{8'sd127, 1'b1}, 1'b0, '0},
    // A zero character that carries the end flag still closes the string.
    '{'{8'sd7, 1'b0}, 1'b0, '0},
    '{'{8'sd0, 1'b1}, 1'b0, '0},
    // Two anagrams of one another: both must give the same hash.
    '{'{8'sd116, 1'b0}, 1'b0, '0},
    '{'{8'sd111, 1'b0}, 1'b0, '0},
    '{'{8'sd112, 1'b1}, 1'b0, '0},
    '{'{8'sd112, 1'b0}, 1'b0, '0},
    '{'{8'sd111, 1'b0}, 1'b0, '0},
    '{'{8'sd116, 1'b1}, 1'b0, '0}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Idling percentages for the current phase, and the request for a long
  // receiver hold-off that the receiver process counts out on its own.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;

  // Behavioural copy of the block's state.
  logic signed [CHAR_W-1:0] sorted_store [MAX_LEN];
  int unsigned              stored_count = 0;
  bit                       dropped_seen = 1'b0;

  out_word_t   pending_digests [$];
  char_tag_t   char_tags [$];
  int unsigned counted_chars = 0;
  int unsigned result_index = 0;
  int unsigned mismatches = 0;

  anagram_invariant_hash dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // The first ten failures are shown in full; later ones are only counted.
  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Takes one character into the sorted store, in the way the block does, and
  // hands back the digest of the string when the word closes it.
  function automatic void absorb_char(input in_word_t w, output bit done,
                                      output out_word_t digest);
    int unsigned              pos;
    logic [HASH_W-1:0]        h;
    logic signed [CHAR_W-1:0] c;
    done = 1'b0;
    digest = '0;
    if (w.char_code != 0) begin
      if (stored_count < MAX_LEN) begin
        // A new character goes after any stored ones that are equal to it.
        pos = stored_count;
        while (pos > 0 && sorted_store[pos-1] > w.char_code) begin
          sorted_store[pos] = sorted_store[pos-1];
          pos--;
        end
        sorted_store[pos] = w.char_code;
        stored_count++;
      end else begin
        // The store is full: the character is lost and the string overflows.
        dropped_seen = 1'b1;
      end
    end
    if (w.last_char) begin
      h = HASH_SEED;
      for (int i = 0; i < stored_count; i++) begin
        c = sorted_store[i];
        h = (h << HASH_SHIFT) + h + {{(HASH_W-CHAR_W){c[CHAR_W-1]}}, c};
      end
      digest.hash_value  = h;
      digest.word_length = LEN_W'(stored_count);
      digest.overflow    = dropped_seen;
      done = 1'b1;
      stored_count = 0;
      dropped_seen = 1'b0;
    end
  endfunction

  // Monitor on both channels. Values are read at the rising edge, before the
  // block or the driver update anything, so the order of processes at the
  // edge does not matter. A result cannot leave in the same cycle as the word
  // that closed its string, so checking the output first is safe.
  always @(posedge clk) begin : monitor
    char_tag_t tag;
    out_word_t digest;
    out_word_t want;
    bit        done;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_digests.size() == 0) begin
          note_failure($sformatf("result %0d with nothing outstanding: hash %h len %0d ovf %b",
                                 result_index, out_data.hash_value, out_data.word_length,
                                 out_data.overflow));
        end else begin
          want = pending_digests.pop_front();
          if (out_data.hash_value !== want.hash_value ||
              out_data.word_length !== want.word_length ||
              out_data.overflow !== want.overflow) begin
            note_failure($sformatf(
              "result %0d: expected hash %h len %0d ovf %b, got hash %h len %0d ovf %b",
              result_index, want.hash_value, want.word_length, want.overflow,
              out_data.hash_value, out_data.word_length, out_data.overflow));
          end
        end
        result_index++;
      end
      if (in_valid && in_ready) begin
        tag = char_tags.pop_front();
        absorb_char(in_data, done, digest);
        // Rows with a hand-written result are held to that value instead.
        if (done) begin
          pending_digests.push_back(tag.typed ? tag.res : digest);
        end
      end
    end
  end

  // Receiver: stalls at random at the phase's rate, or holds off completely
  // for a long stretch when asked, so that the block backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = PRESSURE_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one word and waits until it is taken. An idle gap, if any, comes
  // before valid is raised, so valid is never lowered and raised in one step.
  task automatic send_char(input in_word_t w, input bit typed, input out_word_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    char_tags.push_back('{typed, res});
    in_data  <= w;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (w.char_code != 0 || w.last_char) begin
      counted_chars++;
    end
  endtask

  // Narrow picks come from a five-letter alphabet, so repeats are common.
  function automatic logic signed [CHAR_W-1:0] rand_char(input bit allow_zero,
                                                         input bit narrow);
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(255));
    if (narrow) begin
      b = CHAR_W'(97 + $urandom_range(4));
    end
    if (allow_zero && $urandom_range(7) == 0) begin
      b = '0;
    end
    if (!allow_zero && b == 0) begin
      b = 8'd1;
    end
    return b;
  endfunction

  task automatic send_string(input int unsigned len, input bit allow_zero,
                             input bit narrow, input bit zero_last);
    in_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      w.last_char = (i == len - 1);
      w.char_code = rand_char(allow_zero, narrow);
      if (w.last_char && zero_last) begin
        w.char_code = '0;
      end
      send_char(w, 1'b0, '0);
    end
  endtask

  task automatic send_random_string();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) begin
      // Long strings around the size of the store, overflow included.
      send_string($urandom_range(MAX_LEN + 8, MAX_LEN - 4), 1'($urandom_range(1)),
                  1'b0, 1'($urandom_range(1)));
    end else if (pick == 1) begin
      send_string(1, 1'b1, 1'b0, 1'($urandom_range(1)));
    end else begin
      send_string($urandom_range(10, 1), 1'($urandom_range(1)), ($urandom_range(2) == 0),
                  ($urandom_range(7) == 0));
    end
  endtask

  initial begin : stimulus
    int unsigned waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_char(DIR_TABLE[r].stim, DIR_TABLE[r].typed, DIR_TABLE[r].res);
    end

    // Full store exactly; one character over; full with a zero to close it;
    // well over with a zero to close it.
    send_string(MAX_LEN, 1'b0, 1'b0, 1'b0);
    send_string(MAX_LEN + 1, 1'b0, 1'b0, 1'b0);
    send_string(MAX_LEN + 1, 1'b0, 1'b0, 1'b1);
    send_string(MAX_LEN + 8, 1'b0, 1'b0, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 87;
        end
        3: begin
          send_idle_pct = 37;
          recv_stall_pct = 37;
        end
        default: begin
          // Sender flat out against a receiver that stops for a long while.
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_request = 1'b1;
        end
      endcase
      while (counted_chars < (phase + 1) * PHASE_ITEMS) begin
        send_random_string();
      end
    end

    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    waited = 0;
    while (pending_digests.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // A full walk of the store plus the output register, with some margin,
    // so that any stray result still shows up.
    repeat (MAX_LEN + 8) @(posedge clk);
    if (pending_digests.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_digests.size()));
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
